// File: hdl/srfp_pkg.sv
`default_nettype none

package srfp_pkg;

    localparam int unsigned CountW     = 17;
    localparam int unsigned CfgIndexW  = 3;
    localparam int unsigned CfgDataW   = 32;
    localparam int unsigned InDataW    = 8;
    localparam int unsigned OutDataW   = 184;
    localparam int unsigned QueueDepth = 3;

    // Bytes in a frame header ahead of the payload.
    localparam logic [CountW-1:0] HdrLen = 17'd20;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] CfgSyncWord      = 3'd0;
    localparam logic [CfgIndexW-1:0] CfgDeviceAddress = 3'd1;
    localparam logic [CfgIndexW-1:0] CfgRequestType   = 3'd2;
    localparam logic [CfgIndexW-1:0] CfgDeviceVersion = 3'd3;
    localparam logic [CfgIndexW-1:0] CfgMaxPayload    = 3'd4;

    localparam logic [15:0] SyncWordReset   = 16'h444E;
    localparam logic [15:0] MaxPayloadReset = 16'hFFFF;

    // Result kinds carried on the master tuser.
    localparam logic [1:0] KindPayload   = 2'd0;
    localparam logic [1:0] KindPacketOk  = 2'd1;
    localparam logic [1:0] KindHeaderErr = 2'd2;
    localparam logic [1:0] KindLineErr   = 2'd3;

    typedef struct packed {
        logic        last;
        logic [31:0] status_errors;
        logic [31:0] command_errors;
        logic [31:0] good_packets;
        logic [15:0] reserved_field;
        logic [15:0] crc_field;
        logic [15:0] payload_size;
        logic [15:0] command;
        logic [15:0] payload_index;
        logic [7:0]  payload_byte;
        logic [1:0]  kind;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/serial_request_frame_parser_core.sv
`default_nettype none

// Channel   Signals                        Contents
// s_axis    tvalid tready tdata tuser      received byte, line error flag
// m_axis    tvalid tready tdata tuser tlast  payload bytes and frame events
// cfg       i_cfg_wr_en i_cfg_index i_cfg_wdata  register writes, no read-back
//
// Each byte is parsed in the cycle it is accepted; one per cycle while tready is high.
// A byte yields zero, one or two results, which enter a three-entry output queue.
// The input is ready while the queue holds at most one result, so a stalled output
// stops the input only once two results are waiting.
// Reset is synchronous: the parser hunts for sync and all counters are zero.
module serial_request_frame_parser_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [srfp_pkg::InDataW-1:0]   s_axis_tdata,   // [7:0] rx_byte
    input  wire logic                           s_axis_tuser,   // [0] line_error
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] payload_byte, [23:8] payload_index, [39:24] command, [55:40] payload_size,
    // [71:56] crc_field, [87:72] reserved_field, [119:88] good_packets,
    // [151:120] command_errors, [183:152] status_errors
    output logic [srfp_pkg::OutDataW-1:0]       m_axis_tdata,
    output logic [1:0]                          m_axis_tuser,   // [1:0] kind
    output logic                                m_axis_tlast,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [srfp_pkg::CfgIndexW-1:0] i_cfg_index,
    input  wire logic [srfp_pkg::CfgDataW-1:0]  i_cfg_wdata
);
    import srfp_pkg::*;

    logic [15:0] r_sync_word;
    logic [31:0] r_device_address;
    logic [15:0] r_request_type;
    logic [31:0] r_device_version;
    logic [15:0] r_max_payload;

    logic              r_in_frame,     n_in_frame;
    logic [CountW-1:0] r_byte_count,   n_byte_count;
    logic [15:0]       r_hdr_sync,     n_hdr_sync;
    logic [15:0]       r_hdr_crc,      n_hdr_crc;
    logic [31:0]       r_hdr_device,   n_hdr_device;
    logic [15:0]       r_hdr_type,     n_hdr_type;
    logic [15:0]       r_hdr_command,  n_hdr_command;
    logic [31:0]       r_hdr_version,  n_hdr_version;
    logic [15:0]       r_hdr_size,     n_hdr_size;
    logic [15:0]       r_hdr_reserved, n_hdr_reserved;
    logic [31:0]       r_ok_cnt,       n_ok_cnt;
    logic [31:0]       r_cmd_err_cnt,  n_cmd_err_cnt;
    logic [31:0]       r_stat_err_cnt, n_stat_err_cnt;

    t_result     r_queue [QueueDepth];
    t_result     n_queue [QueueDepth];
    logic [1:0]  r_q_cnt, n_q_cnt;

    logic        accept;
    logic        pop;
    logic [7:0]  rx_byte;
    logic        line_err;
    logic        framing;
    logic        bad;
    logic [1:0]  n_res;
    t_result     res0;
    t_result     res1;
    t_result     res_base;

    assign rx_byte       = s_axis_tdata[7:0];
    assign line_err      = s_axis_tuser;
    assign s_axis_tready = (r_q_cnt <= 2'd1);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_q_cnt != 2'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    assign m_axis_tuser = r_queue[0].kind;
    assign m_axis_tlast = r_queue[0].last;
    assign m_axis_tdata = {r_queue[0].status_errors, r_queue[0].command_errors,
                           r_queue[0].good_packets, r_queue[0].reserved_field,
                           r_queue[0].crc_field, r_queue[0].payload_size,
                           r_queue[0].command, r_queue[0].payload_index,
                           r_queue[0].payload_byte};

    // Parser: header assembly, checks and result generation for one byte.
    always_comb begin
        n_in_frame     = r_in_frame;
        n_byte_count   = r_byte_count;
        n_hdr_sync     = r_hdr_sync;
        n_hdr_crc      = r_hdr_crc;
        n_hdr_device   = r_hdr_device;
        n_hdr_type     = r_hdr_type;
        n_hdr_command  = r_hdr_command;
        n_hdr_version  = r_hdr_version;
        n_hdr_size     = r_hdr_size;
        n_hdr_reserved = r_hdr_reserved;
        n_ok_cnt       = r_ok_cnt;
        n_cmd_err_cnt  = r_cmd_err_cnt;
        n_stat_err_cnt = r_stat_err_cnt;
        bad            = 1'b0;
        n_res          = 2'd0;
        res0           = '0;
        res1           = '0;
        res_base       = '0;

        framing = r_in_frame;
        if (line_err) begin
            n_stat_err_cnt = r_stat_err_cnt + 32'd1;
            n_cmd_err_cnt  = r_cmd_err_cnt + 32'd1;
            n_in_frame     = 1'b0;
            n_byte_count   = '0;
            framing        = 1'b0;
            res0                = '0;
            res0.kind           = KindLineErr;
            res0.command        = r_hdr_command;
            res0.payload_size   = r_hdr_size;
            res0.crc_field      = r_hdr_crc;
            res0.reserved_field = r_hdr_reserved;
            res0.good_packets   = r_ok_cnt;
            res0.command_errors = n_cmd_err_cnt;
            res0.status_errors  = n_stat_err_cnt;
            n_res               = 2'd1;
        end

        if (!framing) begin
            // A line-error byte may itself open a new frame.
            if (rx_byte == r_sync_word[7:0]) begin
                n_in_frame   = 1'b1;
                n_hdr_sync   = {8'h00, rx_byte};
                n_byte_count = 17'd1;
            end
        end else begin
            case (r_byte_count)
                17'd1: begin
                    n_hdr_sync = {rx_byte, r_hdr_sync[7:0]};
                    bad        = (n_hdr_sync != r_sync_word);
                end
                17'd2:  n_hdr_crc    = {8'h00, rx_byte};
                17'd3:  n_hdr_crc    = {rx_byte, r_hdr_crc[7:0]};
                17'd4:  n_hdr_device = {24'h000000, rx_byte};
                17'd5:  n_hdr_device = {16'h0000, rx_byte, r_hdr_device[7:0]};
                17'd6:  n_hdr_device = {8'h00, rx_byte, r_hdr_device[15:0]};
                17'd7: begin
                    n_hdr_device = {rx_byte, r_hdr_device[23:0]};
                    bad          = (n_hdr_device != r_device_address);
                end
                17'd8:  n_hdr_type = {8'h00, rx_byte};
                17'd9: begin
                    n_hdr_type = {rx_byte, r_hdr_type[7:0]};
                    bad        = (n_hdr_type != r_request_type);
                end
                17'd10: n_hdr_command = {8'h00, rx_byte};
                17'd11: n_hdr_command = {rx_byte, r_hdr_command[7:0]};
                17'd12: n_hdr_version = {24'h000000, rx_byte};
                17'd13: n_hdr_version = {16'h0000, rx_byte, r_hdr_version[7:0]};
                17'd14: n_hdr_version = {8'h00, rx_byte, r_hdr_version[15:0]};
                17'd15: begin
                    n_hdr_version = {rx_byte, r_hdr_version[23:0]};
                    bad           = (n_hdr_version != r_device_version);
                end
                17'd16: n_hdr_size = {8'h00, rx_byte};
                17'd17: begin
                    n_hdr_size = {rx_byte, r_hdr_size[7:0]};
                    bad        = (n_hdr_size > r_max_payload);
                end
                17'd18: n_hdr_reserved = {8'h00, rx_byte};
                17'd19: n_hdr_reserved = {rx_byte, r_hdr_reserved[7:0]};
                default: ;
            endcase

            res_base.command        = n_hdr_command;
            res_base.payload_size   = n_hdr_size;
            res_base.crc_field      = n_hdr_crc;
            res_base.reserved_field = n_hdr_reserved;
            res_base.good_packets   = r_ok_cnt;
            res_base.command_errors = r_cmd_err_cnt;
            res_base.status_errors  = r_stat_err_cnt;

            if (r_byte_count >= HdrLen) begin
                res0               = res_base;
                res0.kind          = KindPayload;
                res0.payload_byte  = rx_byte;
                res0.payload_index = 16'(r_byte_count - HdrLen);
                n_res              = 2'd1;
            end

            if (bad) begin
                n_cmd_err_cnt = r_cmd_err_cnt + 32'd1;
                n_in_frame    = 1'b0;
                n_byte_count  = '0;
                res0                = res_base;
                res0.kind           = KindHeaderErr;
                res0.command_errors = n_cmd_err_cnt;
                n_res               = 2'd1;
            end else begin
                n_byte_count = r_byte_count + 17'd1;
                if (n_byte_count >= ({1'b0, n_hdr_size} + HdrLen)) begin
                    n_ok_cnt     = r_ok_cnt + 32'd1;
                    n_in_frame   = 1'b0;
                    n_byte_count = '0;
                    if (n_res == 2'd0) begin
                        res0              = res_base;
                        res0.kind         = KindPacketOk;
                        res0.good_packets = n_ok_cnt;
                        n_res             = 2'd1;
                    end else begin
                        res1              = res_base;
                        res1.kind         = KindPacketOk;
                        res1.good_packets = n_ok_cnt;
                        n_res             = 2'd2;
                    end
                end
            end
        end

        if (n_res == 2'd1) begin
            res0.last = 1'b1;
        end else if (n_res == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    // Output queue: the head sits in entry 0 and the queue shifts on each output transfer.
    always_comb begin
        n_queue = r_queue;
        n_q_cnt = r_q_cnt;
        if (pop) begin
            n_queue[0] = r_queue[1];
            n_queue[1] = r_queue[2];
            n_q_cnt    = r_q_cnt - 2'd1;
        end
        if (accept) begin
            for (int i = 0; i < QueueDepth; i++) begin
                if (n_res != 2'd0 && 2'(i) == n_q_cnt) begin
                    n_queue[i] = res0;
                end else if (n_res == 2'd2 && 2'(i) == n_q_cnt + 2'd1) begin
                    n_queue[i] = res1;
                end
            end
            n_q_cnt = n_q_cnt + n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_queue <= n_queue;
        if (!i_rst_n) begin
            r_q_cnt <= 2'd0;
        end else begin
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame     <= 1'b0;
            r_byte_count   <= '0;
            r_hdr_sync     <= '0;
            r_hdr_crc      <= '0;
            r_hdr_device   <= '0;
            r_hdr_type     <= '0;
            r_hdr_command  <= '0;
            r_hdr_version  <= '0;
            r_hdr_size     <= '0;
            r_hdr_reserved <= '0;
            r_ok_cnt       <= '0;
            r_cmd_err_cnt  <= '0;
            r_stat_err_cnt <= '0;
        end else if (accept) begin
            r_in_frame     <= n_in_frame;
            r_byte_count   <= n_byte_count;
            r_hdr_sync     <= n_hdr_sync;
            r_hdr_crc      <= n_hdr_crc;
            r_hdr_device   <= n_hdr_device;
            r_hdr_type     <= n_hdr_type;
            r_hdr_command  <= n_hdr_command;
            r_hdr_version  <= n_hdr_version;
            r_hdr_size     <= n_hdr_size;
            r_hdr_reserved <= n_hdr_reserved;
            r_ok_cnt       <= n_ok_cnt;
            r_cmd_err_cnt  <= n_cmd_err_cnt;
            r_stat_err_cnt <= n_stat_err_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word      <= SyncWordReset;
            r_device_address <= '0;
            r_request_type   <= '0;
            r_device_version <= '0;
            r_max_payload    <= MaxPayloadReset;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CfgSyncWord:      r_sync_word      <= i_cfg_wdata[15:0];
                CfgDeviceAddress: r_device_address <= i_cfg_wdata;
                CfgRequestType:   r_request_type   <= i_cfg_wdata[15:0];
                CfgDeviceVersion: r_device_version <= i_cfg_wdata;
                CfgMaxPayload:    r_max_payload    <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    a_line_err_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && line_err) |=> (r_stat_err_cnt == $past(r_stat_err_cnt) + 32'd1))
        else $error("line error did not advance the status error counter");

    a_stat_err_only_on_line_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && line_err) |=> $stable(r_stat_err_cnt))
        else $error("status error counter moved without a line error");

    a_hunt_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_byte_count == '0))
        else $error("byte count nonzero while hunting");

    a_payload_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_frame && r_byte_count >= HdrLen)
            |-> (r_byte_count < ({1'b0, r_hdr_size} + HdrLen)))
        else $error("payload position past the end of the frame");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import srfp_pkg::*;

    localparam int StallLimit = 2000;
    localparam int SettleCycles = 16;
    // An index past the last register; writes to it must change nothing.
    localparam logic [CfgIndexW-1:0] CfgNoRegister = 3'd5;

    typedef enum int {FrameClean, FrameBadField, FrameOversize, FrameLineError} t_frame_flaw;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_error;
        logic       drain_first;
    } t_rx_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [InDataW-1:0]   s_axis_tdata = '0;   // [7:0] rx_byte
    logic                 s_axis_tuser = 1'b0; // [0] line_error
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [7:0] payload_byte, [23:8] payload_index, [39:24] command, [55:40] payload_size,
    // [71:56] crc_field, [87:72] reserved_field, [119:88] good_packets,
    // [151:120] command_errors, [183:152] status_errors
    logic [OutDataW-1:0]  m_axis_tdata;
    logic [1:0]           m_axis_tuser;        // [1:0] kind
    logic                 m_axis_tlast;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CfgIndexW-1:0] i_cfg_index = '0;
    logic [CfgDataW-1:0]  i_cfg_wdata = '0;

    serial_request_frame_parser_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Register copies used by the parser model and by the frame builder.
    logic [15:0] cfg_sync = SyncWordReset;
    logic [31:0] cfg_device = '0;
    logic [15:0] cfg_type = '0;
    logic [31:0] cfg_version = '0;
    logic [15:0] cfg_max = MaxPayloadReset;

    // Parser model state.
    logic        in_frame = 1'b0;
    int unsigned frame_pos = 0;
    logic [15:0] rx_sync = '0;
    logic [15:0] rx_crc = '0;
    logic [31:0] rx_device = '0;
    logic [15:0] rx_type = '0;
    logic [15:0] rx_command = '0;
    logic [31:0] rx_version = '0;
    logic [15:0] rx_size = '0;
    logic [15:0] rx_reserved = '0;
    logic [31:0] good_count = '0;
    logic [31:0] cmd_err_count = '0;
    logic [31:0] status_err_count = '0;

    t_rx_item rx_bytes_to_send[$];
    t_result  predicted_events[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_queued = 0;
    int bytes_accepted = 0;
    int events_checked = 0;
    int error_count = 0;
    int kind_count[4] = '{0, 0, 0, 0};
    int stall_cycles = 0;
    logic byte_taken = 1'b0;

    function automatic t_result make_event(logic [1:0] kind, logic [7:0] data,
                                           logic [15:0] index);
        t_result ev;
        ev.kind           = kind;
        ev.payload_byte   = data;
        ev.payload_index  = index;
        ev.command        = rx_command;
        ev.payload_size   = rx_size;
        ev.crc_field      = rx_crc;
        ev.reserved_field = rx_reserved;
        ev.good_packets   = good_count;
        ev.command_errors = cmd_err_count;
        ev.status_errors  = status_err_count;
        ev.last           = 1'b0;
        return ev;
    endfunction

    // Advances the parser model by one received byte and queues the events it causes.
    task automatic parse_rx_byte(input logic [7:0] b, input logic lerr);
        t_result batch[$];
        logic    bad;
        bad = 1'b0;
        if (lerr) begin
            status_err_count++;
            cmd_err_count++;
            in_frame = 1'b0;
            frame_pos = 0;
            batch.push_back(make_event(KindLineErr, 8'h00, 16'h0000));
        end
        if (!in_frame) begin
            if (b == cfg_sync[7:0]) begin
                in_frame = 1'b1;
                rx_sync = {8'h00, b};
                frame_pos = 1;
            end
        end else begin
            case (frame_pos)
                1: begin
                    rx_sync[15:8] = b;
                    bad = (rx_sync != cfg_sync);
                end
                2: rx_crc = {8'h00, b};
                3: rx_crc[15:8] = b;
                4: rx_device = {24'h0, b};
                5: rx_device[15:8] = b;
                6: rx_device[23:16] = b;
                7: begin
                    rx_device[31:24] = b;
                    bad = (rx_device != cfg_device);
                end
                8: rx_type = {8'h00, b};
                9: begin
                    rx_type[15:8] = b;
                    bad = (rx_type != cfg_type);
                end
                10: rx_command = {8'h00, b};
                11: rx_command[15:8] = b;
                12: rx_version = {24'h0, b};
                13: rx_version[15:8] = b;
                14: rx_version[23:16] = b;
                15: begin
                    rx_version[31:24] = b;
                    bad = (rx_version != cfg_version);
                end
                16: rx_size = {8'h00, b};
                17: begin
                    rx_size[15:8] = b;
                    bad = (rx_size > cfg_max);
                end
                18: rx_reserved = {8'h00, b};
                19: rx_reserved[15:8] = b;
                default: begin
                    batch.push_back(make_event(KindPayload, b,
                                               16'(frame_pos - int'(HdrLen))));
                end
            endcase
            if (bad) begin
                cmd_err_count++;
                in_frame = 1'b0;
                frame_pos = 0;
                batch.push_back(make_event(KindHeaderErr, 8'h00, 16'h0000));
            end else begin
                frame_pos++;
                if (frame_pos >= int'(rx_size) + int'(HdrLen)) begin
                    good_count++;
                    in_frame = 1'b0;
                    frame_pos = 0;
                    batch.push_back(make_event(KindPacketOk, 8'h00, 16'h0000));
                end
            end
        end
        if (batch.size() != 0) begin
            batch[batch.size()-1].last = 1'b1;
            foreach (batch[i]) predicted_events.push_back(batch[i]);
        end
    endtask

    function automatic string field_diff(t_result want, t_result seen);
        string s;
        s = "";
        if (want.kind !== seen.kind) s = {s, " kind"};
        if (want.payload_byte !== seen.payload_byte) s = {s, " payload_byte"};
        if (want.payload_index !== seen.payload_index) s = {s, " payload_index"};
        if (want.command !== seen.command) s = {s, " command"};
        if (want.payload_size !== seen.payload_size) s = {s, " payload_size"};
        if (want.crc_field !== seen.crc_field) s = {s, " crc_field"};
        if (want.reserved_field !== seen.reserved_field) s = {s, " reserved_field"};
        if (want.good_packets !== seen.good_packets) s = {s, " good_packets"};
        if (want.command_errors !== seen.command_errors) s = {s, " command_errors"};
        if (want.status_errors !== seen.status_errors) s = {s, " status_errors"};
        if (want.last !== seen.last) s = {s, " last"};
        return s;
    endfunction

    task automatic note_error(input string what, input t_result want, input t_result seen);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR at %0t: %s", $realtime, what);
            $display("  expected %h", want);
            $display("  actual   %h", seen);
        end
    endtask

    // Input acceptance feeds the model, output acceptance is checked against it.
    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        string   diff;
        if (!i_rst_n) begin
            byte_taken = 1'b0;
        end else begin
            byte_taken = s_axis_tvalid && s_axis_tready;
            if (byte_taken) begin
                bytes_accepted++;
                parse_rx_byte(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen = {m_axis_tlast, m_axis_tdata, m_axis_tuser};
                events_checked++;
                if (predicted_events.size() == 0) begin
                    note_error("result transfer with nothing expected", '0, seen);
                end else begin
                    want = predicted_events.pop_front();
                    kind_count[want.kind]++;
                    diff = field_diff(want, seen);
                    if (diff != "") note_error({"mismatch in", diff}, want, seen);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || byte_taken) begin
            // A byte marked drain_first is held back until every pending result is out.
            if (rx_bytes_to_send.size() != 0
                    && !(rx_bytes_to_send[0].drain_first && predicted_events.size() != 0)
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= rx_bytes_to_send[0].rx_byte;
                s_axis_tuser <= rx_bytes_to_send[0].line_error;
                void'(rx_bytes_to_send.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= StallLimit) begin
                $display("timeout: no transfer for %0d cycles", StallLimit);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic lerr, input logic drain);
        t_rx_item item;
        item.rx_byte = b;
        item.line_error = lerr;
        item.drain_first = drain;
        rx_bytes_to_send.push_back(item);
        items_queued++;
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CfgSyncWord:      cfg_sync = value[15:0];
            CfgDeviceAddress: cfg_device = value;
            CfgRequestType:   cfg_type = value[15:0];
            CfgDeviceVersion: cfg_version = value;
            CfgMaxPayload:    cfg_max = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_registers(input logic [15:0] sync, input logic [31:0] device,
                                  input logic [15:0] ptype, input logic [31:0] version,
                                  input logic [15:0] max_size);
        write_reg(CfgSyncWord, {16'h0, sync});
        write_reg(CfgDeviceAddress, device);
        write_reg(CfgRequestType, {16'h0, ptype});
        write_reg(CfgDeviceVersion, version);
        write_reg(CfgMaxPayload, {16'h0, max_size});
        write_reg(CfgNoRegister, $urandom);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Builds one frame for the current register values, optionally damaged.
    task automatic push_frame(input int size_req, input t_frame_flaw flaw, input logic drain);
        logic [159:0] hdr;
        logic [15:0]  size;
        logic [7:0]   frame_bytes[$];
        int           pos;
        int           lerr_pos;
        size = (size_req > int'(cfg_max)) ? cfg_max : 16'(size_req);
        if (flaw == FrameOversize) size = 16'($urandom_range(int'(cfg_max) + 1, 65535));
        hdr = {16'($urandom), size, cfg_version, 16'($urandom), cfg_type, cfg_device,
               16'($urandom), cfg_sync};
        if (flaw == FrameBadField) begin
            pos = $urandom_range(0, 15);
            while (pos == 2 || pos == 3 || pos == 10 || pos == 11) pos = $urandom_range(0, 15);
            hdr[8*pos +: 8] ^= 8'($urandom_range(1, 255));
        end
        for (int p = 0; p < 20; p++) frame_bytes.push_back(hdr[8*p +: 8]);
        if (flaw != FrameOversize) begin
            for (int i = 0; i < int'(size); i++) frame_bytes.push_back(8'($urandom));
        end
        lerr_pos = (flaw == FrameLineError) ? $urandom_range(0, frame_bytes.size() - 1) : -1;
        foreach (frame_bytes[i]) queue_byte(frame_bytes[i], i == lerr_pos, drain && i == 0);
        // A line error on a non-sync byte puts the parser back to hunting after damage.
        if (flaw != FrameClean) queue_byte(cfg_sync[7:0] ^ 8'h01, 1'b1, 1'b0);
    endtask

    task automatic push_random(input int budget);
        int          start;
        int          roll;
        int          sz;
        logic [7:0]  noise;
        start = items_queued;
        while (items_queued - start < budget) begin
            roll = $urandom_range(0, 99);
            sz = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 48);
            if (roll < 62) begin
                push_frame(sz, FrameClean, $urandom_range(0, 24) == 0);
            end else if (roll < 74) begin
                push_frame(sz, FrameBadField, 1'b0);
            end else if (roll < 82) begin
                push_frame(sz, (cfg_max != 16'hFFFF) ? FrameOversize : FrameLineError, 1'b0);
            end else if (roll < 92) begin
                push_frame(sz, FrameLineError, 1'b0);
            end else begin
                // Noise while hunting opens no frame, so it does not count toward the budget.
                repeat ($urandom_range(1, 4)) begin
                    noise = 8'($urandom);
                    if (noise == cfg_sync[7:0]) noise ^= 8'h80;
                    queue_byte(noise, $urandom_range(0, 9) == 0, 1'b0);
                    start++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (rx_bytes_to_send.size() != 0 || s_axis_tvalid || predicted_events.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Back to back, reset register values.
        load_registers(SyncWordReset, 32'h0, 16'h0, 32'h0, MaxPayloadReset);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(cfg_sync[7:0], 1'b1, 1'b0);
        queue_byte(cfg_sync[15:8] ^ 8'h01, 1'b0, 1'b0);
        push_frame(0, FrameClean, 1'b1);
        push_random(200);
        wait_drained();

        // All-ones identity, no payload allowed, sender idling.
        send_idle_pct = 68;
        recv_stall_pct = 0;
        load_registers(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
        push_random(225);
        wait_drained();

        // Zero sync word, small payload limit, receiver stalling.
        send_idle_pct = 0;
        recv_stall_pct = 68;
        load_registers(16'h0000, $urandom, 16'h8000, $urandom,
                       16'($urandom_range(3, 20)));
        push_random(225);
        wait_drained();

        // Random identity, both sides idling.
        send_idle_pct = 28;
        recv_stall_pct = 28;
        load_registers(16'($urandom), $urandom, 16'($urandom), $urandom, MaxPayloadReset);
        push_random(225);
        wait_drained();

        $display("checked %0d results from %0d received bytes: %0d payload bytes, %0d packets",
                 events_checked, bytes_accepted, kind_count[KindPayload],
                 kind_count[KindPacketOk]);
        $display("%0d header errors and %0d line errors over four register sets and idle mixes",
                 kind_count[KindHeaderErr], kind_count[KindLineErr]);
        if (error_count == 0 && predicted_events.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d failed checks, %0d results still expected", error_count,
                     predicted_events.size());
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/srfp_pkg.sv
hdl/serial_request_frame_parser_core.sv
tb/sv/testbench.sv
